### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands for the session timer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// Types, codes and constants shared by the session timer modules.
// ----------------------------------------------------------------------------
package pst_pkg;

    // Phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FOCUS = 2'd1;
    localparam logic [1:0] PH_PAUSE = 2'd2;
    localparam logic [1:0] PH_BREAK = 2'd3;

    // Request modes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_PAUSE = 3'd2;
    localparam logic [2:0] MODE_ABORT = 3'd3;
    localparam logic [2:0] MODE_SKIP  = 3'd4;
    localparam logic [2:0] MODE_RESET = 3'd5;

    // Event codes
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_FOCUS_DONE = 3'd1;
    localparam logic [2:0] EV_ABORTED    = 3'd2;
    localparam logic [2:0] EV_SHORT_DONE = 3'd3;
    localparam logic [2:0] EV_LONG_DONE  = 3'd4;
    localparam logic [2:0] EV_RESET      = 3'd5;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 3;
    localparam int          CFG_DATA_W       = 16;
    localparam logic [2:0]  CFG_FOCUS_LEN    = 3'd0;
    localparam logic [2:0]  CFG_SHORT_LEN    = 3'd1;
    localparam logic [2:0]  CFG_LONG_LEN     = 3'd2;
    localparam logic [2:0]  CFG_RUNS_PER_LB  = 3'd3;
    localparam logic [2:0]  CFG_AUTO_BREAK   = 3'd4;

    // Configuration reset values
    localparam logic [15:0] RST_FOCUS_LEN   = 16'd1500;
    localparam logic [15:0] RST_SHORT_LEN   = 16'd300;
    localparam logic [15:0] RST_LONG_LEN    = 16'd900;
    localparam logic [7:0]  RST_RUNS_PER_LB = 8'd4;
    localparam logic        RST_AUTO_BREAK  = 1'b1;

    // Level thresholds in minutes, turned into seconds at elaboration
    localparam int SECS_PER_MIN = 60;
    localparam logic [31:0] LEVEL1_SECS = 32'(15 * SECS_PER_MIN);
    localparam logic [31:0] LEVEL2_SECS = 32'(60 * SECS_PER_MIN);
    localparam logic [31:0] LEVEL3_SECS = 32'(200 * SECS_PER_MIN);

    // Remainder divider: one quotient bit per step over the 16-bit in-row count
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [2:0] mode;
        logic       day_changed;
    } t_req;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] remaining;
        logic        ticked;
        logic [2:0]  event_res;
        logic [1:0]  level;
        logic        level_changed;
        logic [15:0] runs_in_row;
        logic [23:0] runs_total;
        logic [31:0] total_seconds;
        logic [16:0] today_seconds;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic step;
        logic acc;
        logic lvl;
        logic div_step;
        logic brk;
        logic load_res;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fin_focus;
        logic auto_brk;
        logic div_last;
    } t_sts;

    // Growth level from accumulated focus seconds
    function automatic logic [1:0] level_of(input logic [31:0] total);
        logic [1:0] lv;
        if (total >= LEVEL3_SECS)      lv = 2'd3;
        else if (total >= LEVEL2_SECS) lv = 2'd2;
        else if (total >= LEVEL1_SECS) lv = 2'd1;
        else                           lv = 2'd0;
        return lv;
    endfunction

endpackage

### rtl/pomodoro_session_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomodoro_session_timer_core
// Focus/break countdown sequencer: one tick or command per request, one
// result per request.
// ----------------------------------------------------------------------------
// One request is in work at a time, and the next one is taken while the
// previous result still waits in the output register. A tick or command that
// does not end a focus run passes through the step state and the output
// state, which waits while the previous result is still untaken; one that
// ends a focus run also passes the accumulate and level states and, with
// auto-break on, the 16 steps of the bit-serial remainder divider that decides
// between a short and a long break and a state that loads the break length.
// Configuration writes are meant for when no request is in work.
module pomodoro_session_timer_core
    import pst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_res                  o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    pst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Timer state and counters
    pst_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (o_res)
    );

endmodule

### rtl/pst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer: takes a request, walks the datapath through its steps and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pst_ctrl
    import pst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_res_valid,
    input  logic i_res_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_LVL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_BRK  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_res_valid, n_res_valid;
    logic       res_free;

    assign res_free    = !r_res_valid || i_res_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.fin_focus ? S_ACC : S_OUT;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_LVL;
            end
            S_LVL: begin
                o_cmd.lvl = 1'b1;
                n_state   = i_sts.auto_brk ? S_DIV : S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_BRK;
            end
            S_BRK: begin
                o_cmd.brk = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (res_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on load, drop on take
    always_comb begin
        n_res_valid = r_res_valid;
        if (o_cmd.load_res)   n_res_valid = 1'b1;
        else if (i_res_ready) n_res_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

endmodule

### rtl/pst_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_dp
// Datapath: configuration registers, timer state, counters, remainder
// divider and output register.
// ----------------------------------------------------------------------------
module pst_dp
    import pst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_req                  i_req,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output t_res                  o_res
);

    // Configuration
    logic [15:0] r_focus_len, r_short_len, r_long_len;
    logic [7:0]  r_runs_per_lb;
    logic        r_auto;

    // Latched request
    logic [2:0]  r_mode;
    logic        r_day;

    // Timer state
    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_elapsed, n_elapsed;
    logic        r_long, n_long;
    logic [15:0] r_in_row, n_in_row;
    logic [23:0] r_runs, n_runs;
    logic [31:0] r_total, n_total;
    logic [16:0] r_today, n_today;
    logic [1:0]  r_level, n_level;
    logic        r_ticked, n_ticked;
    logic [2:0]  r_event, n_event;
    logic        r_lchg, n_lchg;

    // Remainder divider
    logic [15:0]          r_div_q, n_div_q;
    logic [7:0]           r_div_rem, n_div_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [7:0]           div_n;
    logic [8:0]           rem_sh;
    logic                 rem_geq;

    t_res        r_res;
    logic        rem_last;
    logic        fin_brk;
    logic [1:0]  lv;
    logic [32:0] sum_total;
    logic [17:0] sum_today;

    assign rem_last  = (r_rem <= 16'd1);
    assign sum_total = {1'b0, r_total} + 33'(r_elapsed);
    assign sum_today = {1'b0, r_today} + 18'(r_elapsed);
    assign lv        = level_of(r_total);

    // Zero runs per long break acts as one
    assign div_n   = (r_runs_per_lb == 8'd0) ? 8'd1 : r_runs_per_lb;
    assign rem_sh  = {r_div_rem, r_div_q[15]};
    assign rem_geq = (rem_sh >= {1'b0, div_n});

    assign o_sts.fin_focus = (r_mode == MODE_TICK) && (r_phase == PH_FOCUS) && rem_last;
    assign o_sts.auto_brk  = r_auto;
    assign o_sts.div_last  = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    assign o_res = r_res;

    // Timer state update
    always_comb begin
        n_phase   = r_phase;
        n_rem     = r_rem;
        n_elapsed = r_elapsed;
        n_long    = r_long;
        n_in_row  = r_in_row;
        n_runs    = r_runs;
        n_total   = r_total;
        n_today   = r_today;
        n_level   = r_level;
        n_ticked  = r_ticked;
        n_event   = r_event;
        n_lchg    = r_lchg;
        n_div_q   = r_div_q;
        n_div_rem = r_div_rem;
        n_div_cnt = r_div_cnt;
        fin_brk   = 1'b0;
        if (i_cmd.step) begin
            n_ticked = 1'b0;
            n_event  = EV_NONE;
            n_lchg   = 1'b0;
            unique case (r_mode)
                MODE_TICK: begin
                    if (r_phase == PH_FOCUS || r_phase == PH_BREAK) begin
                        if (r_rem != 16'd0) begin
                            n_rem     = r_rem - 16'd1;
                            n_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + 16'd1;
                            n_ticked  = 1'b1;
                        end
                        if (rem_last && r_phase == PH_BREAK) fin_brk = 1'b1;
                        if (rem_last && r_phase == PH_FOCUS) n_event = EV_FOCUS_DONE;
                    end
                end
                MODE_START: begin
                    if (r_phase == PH_PAUSE) begin
                        n_phase = PH_FOCUS;
                    end else if (r_phase != PH_FOCUS) begin
                        if (r_phase == PH_BREAK && r_long) n_in_row = '0;
                        n_long = 1'b0;
                        if (r_day) begin
                            n_in_row = '0;
                            n_today  = '0;
                        end
                        n_rem     = r_focus_len;
                        n_elapsed = '0;
                        n_phase   = PH_FOCUS;
                    end
                end
                MODE_PAUSE: begin
                    if (r_phase == PH_FOCUS) n_phase = PH_PAUSE;
                end
                MODE_ABORT: begin
                    if (r_phase == PH_FOCUS || r_phase == PH_PAUSE) begin
                        n_rem     = '0;
                        n_elapsed = '0;
                        n_long    = 1'b0;
                        n_phase   = PH_IDLE;
                        n_event   = EV_ABORTED;
                    end
                end
                MODE_SKIP: begin
                    if (r_phase == PH_BREAK) fin_brk = 1'b1;
                end
                MODE_RESET: begin
                    n_phase   = PH_IDLE;
                    n_rem     = '0;
                    n_elapsed = '0;
                    n_long    = 1'b0;
                    n_in_row  = '0;
                    n_runs    = '0;
                    n_total   = '0;
                    n_today   = '0;
                    n_level   = '0;
                    n_event   = EV_RESET;
                    n_lchg    = 1'b1;
                end
                default: ;
            endcase
            // End the break
            if (fin_brk) begin
                if (r_long) n_in_row = '0;
                n_event   = r_long ? EV_LONG_DONE : EV_SHORT_DONE;
                n_long    = 1'b0;
                n_rem     = '0;
                n_elapsed = '0;
                n_phase   = PH_IDLE;
            end
        end else if (i_cmd.acc) begin
            // Accumulate the finished run
            n_total   = sum_total[32] ? '1 : sum_total[31:0];
            n_today   = sum_today[17] ? '1 : sum_today[16:0];
            n_runs    = (r_runs == '1) ? r_runs : r_runs + 24'd1;
            n_in_row  = (r_in_row == '1) ? r_in_row : r_in_row + 16'd1;
            n_rem     = '0;
            n_elapsed = '0;
            if (r_auto) begin
                n_phase = PH_BREAK;
            end else begin
                n_phase = PH_IDLE;
                n_long  = 1'b0;
            end
        end else if (i_cmd.lvl) begin
            // Recompute level, load the divider
            n_level   = lv;
            n_lchg    = (lv != r_level);
            n_div_q   = r_in_row;
            n_div_rem = '0;
            n_div_cnt = '0;
        end else if (i_cmd.div_step) begin
            // One restoring step of in_row mod n
            n_div_rem = rem_geq ? 8'(rem_sh - {1'b0, div_n}) : rem_sh[7:0];
            n_div_q   = {r_div_q[14:0], 1'b0};
            n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
        end else if (i_cmd.brk) begin
            // Choose the break length
            n_long = (r_div_rem == 8'd0);
            n_rem  = (r_div_rem == 8'd0) ? r_long_len : r_short_len;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus_len   <= RST_FOCUS_LEN;
            r_short_len   <= RST_SHORT_LEN;
            r_long_len    <= RST_LONG_LEN;
            r_runs_per_lb <= RST_RUNS_PER_LB;
            r_auto        <= RST_AUTO_BREAK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FOCUS_LEN:   r_focus_len   <= i_cfg_data;
                CFG_SHORT_LEN:   r_short_len   <= i_cfg_data;
                CFG_LONG_LEN:    r_long_len    <= i_cfg_data;
                CFG_RUNS_PER_LB: r_runs_per_lb <= i_cfg_data[7:0];
                CFG_AUTO_BREAK:  r_auto        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_rem     <= '0;
            r_elapsed <= '0;
            r_long    <= 1'b0;
            r_in_row  <= '0;
            r_runs    <= '0;
            r_total   <= '0;
            r_today   <= '0;
            r_level   <= '0;
            r_ticked  <= 1'b0;
            r_event   <= EV_NONE;
            r_lchg    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_rem     <= n_rem;
            r_elapsed <= n_elapsed;
            r_long    <= n_long;
            r_in_row  <= n_in_row;
            r_runs    <= n_runs;
            r_total   <= n_total;
            r_today   <= n_today;
            r_level   <= n_level;
            r_ticked  <= n_ticked;
            r_event   <= n_event;
            r_lchg    <= n_lchg;
        end
    end

    // Request latch, divider and output register
    always_ff @(posedge i_clk) begin
        r_div_q   <= n_div_q;
        r_div_rem <= n_div_rem;
        r_div_cnt <= n_div_cnt;
        if (i_cmd.load_req) begin
            r_mode <= i_req.mode;
            r_day  <= i_req.day_changed;
        end
        if (i_cmd.load_res) begin
            r_res.phase         <= r_phase;
            r_res.remaining     <= r_rem;
            r_res.ticked        <= r_ticked;
            r_res.event_res     <= r_event;
            r_res.level         <= r_level;
            r_res.level_changed <= r_lchg;
            r_res.runs_in_row   <= r_in_row;
            r_res.runs_total    <= r_runs;
            r_res.total_seconds <= r_total;
            r_res.today_seconds <= r_today;
        end
    end

endmodule

### rtl/pst_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_chk
// Port-level checks on the session timer results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pst_chk
    import pst_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_res_valid,
    input logic i_res_ready,
    input t_res o_res
);

    // Hold a stalled result
    `PST_ASSERT_NEXT(a_res_hold, o_res_valid && !i_res_ready, o_res_valid && $stable(o_res), "result changed while stalled")

    // Idle always shows no time left
    `PST_ASSERT_IMP(a_idle_rem, o_res_valid && o_res.phase == PH_IDLE, o_res.remaining == 16'd0, "idle with time left")

    // A finished run leaves the block idle or in a break
    `PST_ASSERT_IMP(a_focus_done, o_res_valid && o_res.event_res == EV_FOCUS_DONE, o_res.phase == PH_IDLE || o_res.phase == PH_BREAK, "focus done in wrong phase")

    // Reset all clears the counters and flags a level change
    `PST_ASSERT_IMP(a_reset_all, o_res_valid && o_res.event_res == EV_RESET, o_res.runs_total == 24'd0 && o_res.total_seconds == 32'd0 && o_res.level_changed, "reset left state behind")

    // A countdown without an event stays in focus or break
    `PST_ASSERT_IMP(a_tick_phase, o_res_valid && o_res.ticked && o_res.event_res == EV_NONE, o_res.phase == PH_FOCUS || o_res.phase == PH_BREAK, "tick outside a run")

endmodule

bind pomodoro_session_timer_core pst_chk u_pst_chk (.*);

### test/pomodoro_session_timer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomodoro_session_timer_checker
// Watches the request, result and register ports of the session timer,
// keeps its own copy of the timer state and settings, predicts the result of
// every accepted request and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module pomodoro_session_timer_checker
    import pst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  t_req                  i_req,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  t_res                  i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 100;
    localparam int LEVEL_MINUTES [4] = '{0, 15, 60, 200};

    // Timer settings as last written
    logic [15:0] focus_len;
    logic [15:0] short_len;
    logic [15:0] long_len;
    logic [7:0]  runs_per_long;
    logic        auto_break;

    // Session state
    logic [1:0]  cur_phase;
    logic [15:0] time_left;
    logic [15:0] focus_elapsed;
    logic        long_due;
    logic [15:0] row_runs;
    logic [23:0] done_runs;
    logic [31:0] focus_total;
    logic [16:0] focus_today;
    logic [1:0]  growth_level;

    t_res predicted_results [$];
    int   fail_count   = 0;
    int   results_seen = 0;

    assign o_fail_count = fail_count;

    // Print one line per mismatch (capped) and count it
    task automatic report_mismatch(input string what);
        if (fail_count < MAX_REPORTS)
            $display("%0t ns: result %0d: %s", $time, results_seen, what);
        fail_count++;
    endtask

    // Close the current break and return its event code
    task automatic end_break(output logic [2:0] ev);
        ev = long_due ? EV_LONG_DONE : EV_SHORT_DONE;
        if (long_due)
            row_runs = '0;
        long_due      = 1'b0;
        time_left     = '0;
        focus_elapsed = '0;
        cur_phase     = PH_IDLE;
    endtask

    // Advance the session by one request and build the result it yields
    task automatic advance_session(input t_req req, output t_res res);
        logic        ticked;
        logic [2:0]  ev;
        logic        lvl_chg;
        logic [32:0] total_sum;
        logic [17:0] today_sum;
        logic [1:0]  new_level;
        logic [7:0]  period;
        int          minutes;

        ticked  = 1'b0;
        ev      = EV_NONE;
        lvl_chg = 1'b0;
        case (req.mode)
            MODE_TICK: begin
                if (cur_phase == PH_FOCUS || cur_phase == PH_BREAK) begin
                    if (time_left != 0) begin
                        time_left--;
                        if (focus_elapsed != 16'hFFFF)
                            focus_elapsed++;
                        ticked = 1'b1;
                    end
                    if (time_left == 0 && cur_phase == PH_BREAK) begin
                        end_break(ev);
                    end else if (time_left == 0) begin
                        // bank the run time and bump the run counters, saturating
                        total_sum   = {1'b0, focus_total} + focus_elapsed;
                        focus_total = total_sum[32] ? '1 : total_sum[31:0];
                        today_sum   = {1'b0, focus_today} + focus_elapsed;
                        focus_today = today_sum[17] ? '1 : today_sum[16:0];
                        if (done_runs != '1)
                            done_runs++;
                        if (row_runs != '1)
                            row_runs++;
                        // regrade from whole minutes of focus
                        minutes   = focus_total / SECS_PER_MIN;
                        new_level = 2'd0;
                        for (int i = 1; i < 4; i++)
                            if (minutes >= LEVEL_MINUTES[i])
                                new_level = 2'(i);
                        lvl_chg       = (new_level != growth_level);
                        growth_level  = new_level;
                        time_left     = '0;
                        focus_elapsed = '0;
                        ev            = EV_FOCUS_DONE;
                        // go idle, or pick a short or long break
                        if (!auto_break) begin
                            long_due  = 1'b0;
                            cur_phase = PH_IDLE;
                        end else begin
                            period    = (runs_per_long == 0) ? 8'd1 : runs_per_long;
                            long_due  = ((row_runs % period) == 0);
                            time_left = long_due ? long_len : short_len;
                            cur_phase = PH_BREAK;
                        end
                    end
                end
            end
            MODE_START: begin
                if (cur_phase == PH_PAUSE) begin
                    cur_phase = PH_FOCUS;
                end else if (cur_phase != PH_FOCUS) begin
                    if (cur_phase == PH_BREAK && long_due)
                        row_runs = '0;
                    long_due = 1'b0;
                    if (req.day_changed) begin
                        row_runs    = '0;
                        focus_today = '0;
                    end
                    time_left     = focus_len;
                    focus_elapsed = '0;
                    cur_phase     = PH_FOCUS;
                end
            end
            MODE_PAUSE: begin
                if (cur_phase == PH_FOCUS)
                    cur_phase = PH_PAUSE;
            end
            MODE_ABORT: begin
                if (cur_phase == PH_FOCUS || cur_phase == PH_PAUSE) begin
                    time_left     = '0;
                    focus_elapsed = '0;
                    long_due      = 1'b0;
                    cur_phase     = PH_IDLE;
                    ev            = EV_ABORTED;
                end
            end
            MODE_SKIP: begin
                if (cur_phase == PH_BREAK)
                    end_break(ev);
            end
            MODE_RESET: begin
                cur_phase     = PH_IDLE;
                time_left     = '0;
                focus_elapsed = '0;
                long_due      = 1'b0;
                row_runs      = '0;
                done_runs     = '0;
                focus_total   = '0;
                focus_today   = '0;
                growth_level  = '0;
                ev            = EV_RESET;
                lvl_chg       = 1'b1;
            end
            default: ;
        endcase

        res.phase         = cur_phase;
        res.remaining     = time_left;
        res.ticked        = ticked;
        res.event_res     = ev;
        res.level         = growth_level;
        res.level_changed = lvl_chg;
        res.runs_in_row   = row_runs;
        res.runs_total    = done_runs;
        res.total_seconds = focus_total;
        res.today_seconds = focus_today;
    endtask

    always @(posedge i_clk) begin
        t_res want;

        if (!i_rst_n) begin
            // restore register defaults and clear the session
            focus_len     = RST_FOCUS_LEN;
            short_len     = RST_SHORT_LEN;
            long_len      = RST_LONG_LEN;
            runs_per_long = RST_RUNS_PER_LB;
            auto_break    = RST_AUTO_BREAK;
            cur_phase     = PH_IDLE;
            time_left     = '0;
            focus_elapsed = '0;
            long_due      = 1'b0;
            row_runs      = '0;
            done_runs     = '0;
            focus_total   = '0;
            focus_today   = '0;
            growth_level  = '0;
            predicted_results.delete();
        end else begin
            // compare an accepted result with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    want = predicted_results.pop_front();
                    if (i_res.phase !== want.phase)
                        report_mismatch($sformatf("phase %0h, expected %0h",
                            i_res.phase, want.phase));
                    if (i_res.remaining !== want.remaining)
                        report_mismatch($sformatf("remaining %0h, expected %0h",
                            i_res.remaining, want.remaining));
                    if (i_res.ticked !== want.ticked)
                        report_mismatch($sformatf("ticked %0h, expected %0h",
                            i_res.ticked, want.ticked));
                    if (i_res.event_res !== want.event_res)
                        report_mismatch($sformatf("event_res %0h, expected %0h",
                            i_res.event_res, want.event_res));
                    if (i_res.level !== want.level)
                        report_mismatch($sformatf("level %0h, expected %0h",
                            i_res.level, want.level));
                    if (i_res.level_changed !== want.level_changed)
                        report_mismatch($sformatf("level_changed %0h, expected %0h",
                            i_res.level_changed, want.level_changed));
                    if (i_res.runs_in_row !== want.runs_in_row)
                        report_mismatch($sformatf("runs_in_row %0h, expected %0h",
                            i_res.runs_in_row, want.runs_in_row));
                    if (i_res.runs_total !== want.runs_total)
                        report_mismatch($sformatf("runs_total %0h, expected %0h",
                            i_res.runs_total, want.runs_total));
                    if (i_res.total_seconds !== want.total_seconds)
                        report_mismatch($sformatf("total_seconds %0h, expected %0h",
                            i_res.total_seconds, want.total_seconds));
                    if (i_res.today_seconds !== want.today_seconds)
                        report_mismatch($sformatf("today_seconds %0h, expected %0h",
                            i_res.today_seconds, want.today_seconds));
                end
            end

            // track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FOCUS_LEN:   focus_len     = i_cfg_data[15:0];
                    CFG_SHORT_LEN:   short_len     = i_cfg_data[15:0];
                    CFG_LONG_LEN:    long_len      = i_cfg_data[15:0];
                    CFG_RUNS_PER_LB: runs_per_long = i_cfg_data[7:0];
                    CFG_AUTO_BREAK:  auto_break    = i_cfg_data[0];
                    default: ;
                endcase
            end

            // predict the result of an accepted request
            if (i_req_valid && i_req_ready) begin
                advance_session(i_req, want);
                predicted_results.push_back(want);
            end
        end
        o_pending <= predicted_results.size();
    end

endmodule

### test/pomodoro_session_timer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomodoro_session_timer_core_tb
// Drives the session timer with a directed sequence of commands and ticks,
// then with random request streams under several register settings and idle
// patterns, including a long result stall and runs up to the first level.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module pomodoro_session_timer_core_tb;
    import pst_pkg::*;

    localparam int RANDOM_ITEMS     = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LEVEL_RUN_LEN    = 450;
    localparam int LEVEL_RUNS       = 2;
    localparam int SETTLE_CYCLES    = 30;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    t_req                  req       = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    t_res                  res;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   tx_idle_pct = 34;
    int   rx_idle_pct = 78;
    logic hold_toggle = 1'b0;
    int   fail_count;
    int   pending;

    always #2 clk = ~clk;

    pomodoro_session_timer_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pomodoro_session_timer_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res        (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, plus a long hold-off each time it is asked for
    initial begin
        int   hold_left;
        logic seen_toggle;

        hold_left   = 0;
        seen_toggle = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Hard stop for a hung run
    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic offer_request(input logic [2:0] mode, input logic day);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid       <= 1'b1;
        req.mode        <= mode;
        req.day_changed <= day;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic wait_results_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Drain the block, then rewrite every timer register
    task automatic apply_settings(input logic [15:0] focus, input logic [15:0] short_brk,
                                  input logic [15:0] long_brk, input logic [7:0] runs,
                                  input logic auto_brk);
        wait_results_drained();
        write_setting(CFG_FOCUS_LEN, focus);
        write_setting(CFG_SHORT_LEN, short_brk);
        write_setting(CFG_LONG_LEN, long_brk);
        write_setting(CFG_RUNS_PER_LB, 16'(runs));
        write_setting(CFG_AUTO_BREAK, 16'(auto_brk));
        cfg_we <= 1'b0;
    endtask

    // Mostly ticks and the commands of a normal session, some unused codes
    function automatic t_req random_request();
        t_req r;
        int   roll;

        roll = $urandom_range(99);
        if (roll < 55)
            r.mode = MODE_TICK;
        else if (roll < 72)
            r.mode = MODE_START;
        else if (roll < 79)
            r.mode = MODE_PAUSE;
        else if (roll < 85)
            r.mode = MODE_ABORT;
        else if (roll < 93)
            r.mode = MODE_SKIP;
        else if (roll < 95)
            r.mode = MODE_RESET;
        else
            r.mode = 3'($urandom_range(7));
        r.day_changed = ($urandom_range(4) == 0);
        return r;
    endfunction

    task automatic run_random(input int count, input int hold_at);
        t_req r;

        for (int n = 0; n < count; n++) begin
            if (n == hold_at)
                hold_toggle <= ~hold_toggle;
            r = random_request();
            offer_request(r.mode, r.day_changed);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults: commands outside their phase, pause and resume, unused codes, abort and reset
        offer_request(MODE_TICK, 1'b0);
        offer_request(MODE_PAUSE, 1'b0);
        offer_request(MODE_ABORT, 1'b0);
        offer_request(MODE_SKIP, 1'b0);
        offer_request(MODE_START, 1'b1);
        offer_request(MODE_START, 1'b0);
        offer_request(MODE_TICK, 1'b0);
        offer_request(MODE_PAUSE, 1'b0);
        offer_request(MODE_TICK, 1'b0);
        offer_request(MODE_START, 1'b1);
        offer_request(3'd6, 1'b0);
        offer_request(3'd7, 1'b1);
        offer_request(MODE_ABORT, 1'b0);
        offer_request(MODE_RESET, 1'b0);

        // Every run ends in a full-length long break; start and skip end it
        apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1);
        offer_request(MODE_START, 1'b0);
        offer_request(MODE_TICK, 1'b0);
        offer_request(MODE_TICK, 1'b0);
        offer_request(MODE_START, 1'b1);
        offer_request(MODE_TICK, 1'b0);
        offer_request(MODE_SKIP, 1'b0);

        // Zero-length run and break end on the first tick
        apply_settings(16'd0, 16'd0, 16'hFFFF, 8'd2, 1'b1);
        offer_request(MODE_START, 1'b0);
        offer_request(MODE_TICK, 1'b0);
        offer_request(MODE_TICK, 1'b0);
        offer_request(MODE_SKIP, 1'b0);

        // Longest run, no auto-break
        apply_settings(16'hFFFF, 16'd1, 16'd1, 8'd255, 1'b0);
        offer_request(MODE_START, 1'b0);
        offer_request(MODE_TICK, 1'b0);
        offer_request(MODE_ABORT, 1'b0);

        // Sender sparse, receiver starved; one long stall to back up the input
        apply_settings(16'd3, 16'd2, 16'd3, 8'd3, 1'b1);
        run_random(RANDOM_ITEMS, RANDOM_ITEMS / 2);

        // Sender starved, receiver sparse; every break long
        tx_idle_pct <= 78;
        rx_idle_pct <= 34;
        apply_settings(16'd2, 16'd0, 16'hFFFF, 8'd1, 1'b1);
        run_random(RANDOM_ITEMS, -1);

        // Back to back: zero lengths with zero runs per long break
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        apply_settings(16'd0, 16'd0, 16'd0, 8'd0, 1'b1);
        run_random(RANDOM_ITEMS / 2, -1);

        // Back to back: no auto-break, widest run count
        apply_settings(16'd5, 16'd1, 16'd2, 8'd255, 1'b0);
        run_random(RANDOM_ITEMS / 2, -1);

        // Long runs to climb to the first level, then clear it all
        apply_settings(16'(LEVEL_RUN_LEN), 16'd1, 16'd1, 8'd3, 1'b0);
        for (int run = 0; run < LEVEL_RUNS; run++) begin
            offer_request(MODE_START, run == 1);
            for (int s = 0; s < LEVEL_RUN_LEN; s++)
                offer_request(MODE_TICK, 1'b0);
        end
        offer_request(MODE_RESET, 1'b0);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_ctrl.sv
rtl/pst_dp.sv
rtl/pomodoro_session_timer_core.sv
rtl/pst_chk.sv
test/pomodoro_session_timer_checker.sv
test/pomodoro_session_timer_core_tb.sv
